FILE: src/mdghp_pkg.sv
// Package for the MOT data group header parser.
// Holds the widths, the status codes and the group record passed from front to back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mdghp_pkg;

	localparam int CRC_BYTES       = 2;
	localparam int MAX_GROUP_BYTES = 16383;
	localparam int LEN_W           = $clog2(MAX_GROUP_BYTES + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 56;
	localparam int OUT_USER_W = 4;

	localparam logic [3:0] GT_HEADER    = 4'd3;
	localparam logic [3:0] GT_BODY      = 4'd4;
	localparam logic [3:0] GT_DIRECTORY = 4'd6;

	typedef enum logic [3:0] {
		ST_OK,
		ST_SHORT_GROUP_HDR,
		ST_NO_CRC,
		ST_NO_SEG_FLAG,
		ST_NO_USER_ACCESS,
		ST_SHORT_SESSION,
		ST_NO_TID_FLAG,
		ST_LEN_IND_LOW,
		ST_SHORT_TID,
		ST_SHORT_SEG_HDR,
		ST_SIZE_MISMATCH,
		ST_TYPE_REFUSED
	} status_t;

	// Everything the checks need about one completed group.
	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             ext;
		logic [2:0]       flags;       // CRC, segment, user access flags
		logic [3:0]       group_type;
		logic             last_segment;
		logic [14:0]      segment_number;
		logic             tid_flag;
		logic [3:0]       length_ind;
		logic [15:0]      object_id;
		logic [12:0]      segment_size;
	} group_rec_t;

endpackage
`default_nettype wire

FILE: src/mot_data_group_header_parser_unit.sv
// MOT data group header parser, top level.
// Instantiates mdghp_front, mdghp_queue and mdghp_back; depends on mdghp_pkg.
//
// Usage:
//   Slave channel s_*: one byte of a MOT data group per transaction, s_tlast on the
//   final byte (CRC bytes included). Master channel m_*: one result per group, the
//   status on m_tuser and the parsed header fields on m_tdata.
//   cfg_wr_en/cfg_wr_data write the directory mode bit (1: directory and body
//   groups, 0: header and body groups); write it only while no group is in flight.
// Throughput: one byte per cycle, sustained while results are taken; a result per group,
//   even for groups of one byte. The front end captures fields as bytes pass and pushes
//   a record into a two-entry queue on the final byte; the checker runs the ordered
//   checks combinationally on the queue head.
// Path: the record is written into the queue when the final byte is taken and moves
//   into the output register when the checker pops the queue head; m_tvalid is that
//   register's valid bit.
// Reset: arst_n clears the parser state, the queue and the directory mode bit; no
//   results are pending afterwards.
// Stall: while m_tready is low the result holds; the queue absorbs two more
//   groups, after which s_tready falls until a result is taken.
`timescale 1ns / 1ps
`default_nettype none
module mot_data_group_header_parser_unit
	import mdghp_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_wr_en,
	input  wire                   cfg_wr_data,   // dir_mode
	input  wire                   s_tvalid,
	output logic                  s_tready,
	input  wire  [IN_DATA_W-1:0]  s_tdata,       // [7:0] data_byte
	input  wire                   s_tlast,       // end_of_group
	output logic                  m_tvalid,
	input  wire                   m_tready,
	// [3:0] group_type, [4] last_segment, [19:5] segment_number,
	// [35:20] object_id, [48:36] segment_size, [53:49] payload_offset, [55:54] zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [OUT_USER_W-1:0] m_tuser        // [3:0] status
);

	logic       q_full;
	logic       q_push;
	logic       q_pop;
	logic       q_not_empty;
	group_rec_t wr_rec;
	group_rec_t head_rec;

	mdghp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_rec    (wr_rec)
	);

	mdghp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_rec    (wr_rec),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_rec  (head_rec)
	);

	mdghp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_not_empty (q_not_empty),
		.q_head      (head_rec),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

endmodule
`default_nettype wire

FILE: src/mdghp_front.sv
// Front end of the MOT data group header parser: takes bytes, captures header fields.
// On the final byte it pushes one group record to the queue. Depends on mdghp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mdghp_front
	import mdghp_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  wire  [IN_DATA_W-1:0] s_tdata,   // [7:0] data_byte
	input  wire                  s_tlast,
	input  wire                  q_full,
	output logic                 q_push,
	output group_rec_t           q_rec
);

	logic [LEN_W-1:0] byte_idx_q;
	logic             ext_q;
	logic [2:0]       flags_q;
	logic [3:0]       gtype_q;
	logic             last_seg_q;
	logic [14:0]      seg_num_q;
	logic             tid_flag_q;
	logic [3:0]       li_q;
	logic [15:0]      tid_q;
	logic [12:0]      seg_size_q;

	group_rec_t       nxt;
	logic [2:0]       s_off;
	logic [4:0]       h_off;
	logic [7:0]       b;
	logic             accept;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign b        = s_tdata;
	assign s_off    = ext_q ? 3'd4 : 3'd2;
	assign h_off    = 5'(s_off) + 5'd3 + 5'(li_q);

	always_comb begin
		nxt.ext            = ext_q;
		nxt.flags          = flags_q;
		nxt.group_type     = gtype_q;
		nxt.last_segment   = last_seg_q;
		nxt.segment_number = seg_num_q;
		nxt.tid_flag       = tid_flag_q;
		nxt.length_ind     = li_q;
		nxt.object_id      = tid_q;
		nxt.segment_size   = seg_size_q;
		nxt.len            = (byte_idx_q < LEN_W'(MAX_GROUP_BYTES)) ?
		                     byte_idx_q + LEN_W'(1) : byte_idx_q;

		if (byte_idx_q == '0) begin
			nxt.ext        = b[7];
			nxt.flags      = b[6:4];
			nxt.group_type = b[3:0];
		end else if (byte_idx_q == LEN_W'(s_off)) begin
			nxt.last_segment   = b[7];
			nxt.segment_number = {b[6:0], 8'h00};
		end else if (byte_idx_q == LEN_W'(s_off) + LEN_W'(1)) begin
			nxt.segment_number = {seg_num_q[14:8], b};
		end else if (byte_idx_q == LEN_W'(s_off) + LEN_W'(2)) begin
			nxt.tid_flag   = b[4];
			nxt.length_ind = b[3:0];
		end else if (byte_idx_q == LEN_W'(s_off) + LEN_W'(3)) begin
			nxt.object_id = {b, 8'h00};
		end else if (byte_idx_q == LEN_W'(s_off) + LEN_W'(4)) begin
			nxt.object_id = {tid_q[15:8], b};
		end

		// The segmentation header starts after the transport id and any skipped bytes.
		if (byte_idx_q >= LEN_W'(s_off) + LEN_W'(5)) begin
			if (byte_idx_q == LEN_W'(h_off)) begin
				nxt.segment_size = {b[4:0], 8'h00};
			end else if (byte_idx_q == LEN_W'(h_off) + LEN_W'(1)) begin
				nxt.segment_size = {seg_size_q[12:8], b};
			end
		end
	end

	assign q_push = accept && s_tlast;
	assign q_rec  = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= '0;
			ext_q      <= 1'b0;
			flags_q    <= '0;
			gtype_q    <= '0;
			last_seg_q <= 1'b0;
			seg_num_q  <= '0;
			tid_flag_q <= 1'b0;
			li_q       <= '0;
			tid_q      <= '0;
			seg_size_q <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				byte_idx_q <= '0;
				ext_q      <= 1'b0;
				flags_q    <= '0;
				gtype_q    <= '0;
				last_seg_q <= 1'b0;
				seg_num_q  <= '0;
				tid_flag_q <= 1'b0;
				li_q       <= '0;
				tid_q      <= '0;
				seg_size_q <= '0;
			end else begin
				byte_idx_q <= nxt.len;
				ext_q      <= nxt.ext;
				flags_q    <= nxt.flags;
				gtype_q    <= nxt.group_type;
				last_seg_q <= nxt.last_segment;
				seg_num_q  <= nxt.segment_number;
				tid_flag_q <= nxt.tid_flag;
				li_q       <= nxt.length_ind;
				tid_q      <= nxt.object_id;
				seg_size_q <= nxt.segment_size;
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/mdghp_queue.sv
// Short queue of group records between the front end and the checker.
// Register array with read from the head. Depends on mdghp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mdghp_queue
	import mdghp_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        push,
	input  group_rec_t wr_rec,
	output logic       full,
	input  wire        pop,
	output logic       not_empty,
	output group_rec_t head_rec
);

	group_rec_t             mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]    wr_ptr_q;
	logic [QUEUE_AW-1:0]    rd_ptr_q;
	logic [QUEUE_AW:0]      count_q;

	assign full      = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_rec  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QUEUE_AW+1)'(1);
				2'b01:   count_q <= count_q - (QUEUE_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QUEUE_AW+1)'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule
`default_nettype wire

FILE: src/mdghp_back.sv
// Checker of the MOT data group header parser: runs the ordered checks on a group record.
// Holds the directory mode register and the output register. Depends on mdghp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mdghp_back
	import mdghp_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_wr_en,
	input  wire                   cfg_wr_data,
	input  wire                   q_not_empty,
	input  group_rec_t            q_head,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  wire                   m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [OUT_USER_W-1:0] m_tuser
);

	logic                  dir_mode_q;
	logic                  out_valid_q;
	status_t               status_q;
	logic [3:0]            gtype_q;
	logic                  last_seg_q;
	logic [14:0]           seg_num_q;
	logic [15:0]           tid_q;
	logic [12:0]           seg_size_q;
	logic [4:0]            offset_q;

	status_t               st;
	logic [2:0]            s_off;
	logic [4:0]            h_off;
	logic [4:0]            h2;
	logic [5:0]            h_crc;
	logic [LEN_W-1:0]      diff;
	logic                  mismatch;
	logic                  type_ok;
	logic                  fields_ok;

	assign s_off    = q_head.ext ? 3'd4 : 3'd2;
	assign h_off    = 5'(s_off) + 5'd3 + 5'(q_head.length_ind);
	assign h2       = h_off + 5'd2;
	assign h_crc    = 6'(h2) + 6'(CRC_BYTES);
	assign diff     = q_head.len - LEN_W'(h_crc);
	assign mismatch = (q_head.len < LEN_W'(h_crc)) ||
	                  (LEN_W'(q_head.segment_size) != diff);
	assign type_ok  = (q_head.group_type == GT_BODY) ||
	                  (dir_mode_q ? (q_head.group_type == GT_DIRECTORY)
	                              : (q_head.group_type == GT_HEADER));

	always_comb begin
		if (q_head.len < LEN_W'(2))                        st = ST_SHORT_GROUP_HDR;
		else if (!q_head.flags[2])                         st = ST_NO_CRC;
		else if (!q_head.flags[1])                         st = ST_NO_SEG_FLAG;
		else if (!q_head.flags[0])                         st = ST_NO_USER_ACCESS;
		else if (q_head.len < LEN_W'(s_off) + LEN_W'(3))   st = ST_SHORT_SESSION;
		else if (!q_head.tid_flag)                         st = ST_NO_TID_FLAG;
		else if (q_head.length_ind < 4'd2)                 st = ST_LEN_IND_LOW;
		else if (q_head.len < LEN_W'(h_off))               st = ST_SHORT_TID;
		else if (q_head.len < LEN_W'(h2))                  st = ST_SHORT_SEG_HDR;
		else if (mismatch)                                 st = ST_SIZE_MISMATCH;
		else if (!type_ok)                                 st = ST_TYPE_REFUSED;
		else                                               st = ST_OK;
	end

	assign fields_ok = (st == ST_OK) || (st == ST_TYPE_REFUSED);
	assign q_pop     = q_not_empty && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_mode_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				dir_mode_q <= cfg_wr_data;
			end
			if (q_pop) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			status_q   <= st;
			gtype_q    <= q_head.group_type;
			last_seg_q <= fields_ok ? q_head.last_segment : 1'b0;
			seg_num_q  <= fields_ok ? q_head.segment_number : '0;
			tid_q      <= fields_ok ? q_head.object_id : '0;
			seg_size_q <= fields_ok ? q_head.segment_size : '0;
			offset_q   <= fields_ok ? h2 : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {2'b00, offset_q, seg_size_q, tid_q, seg_num_q, last_seg_q, gtype_q};

	a_err_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status_q != ST_OK && status_q != ST_TYPE_REFUSED
		|-> offset_q == '0 && tid_q == '0 && seg_num_q == '0 && seg_size_q == '0)
		else $error("error result carries header fields");

	a_ok_offset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status_q == ST_OK |-> offset_q >= 5'd9)
		else $error("payload offset below the smallest header size");

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> m_tvalid)
		else $error("record taken from queue but no result shown");

endmodule
`default_nettype wire

FILE: bench/mot_data_group_header_parser_unit_test.sv
// Self-checking bench for mot_data_group_header_parser_unit: feeds MOT data groups byte by byte
// and compares every result with an in-bench model of the header parser or a directed result.
// Depends on mdghp_pkg and the RTL under src; reads no files.
`timescale 1ns / 1ps
module mot_data_group_header_parser_unit_test;
	import mdghp_pkg::*;

	typedef struct packed {
		status_t     status;
		logic [3:0]  group_type;
		logic        last_segment;
		logic [14:0] segment_number;
		logic [15:0] object_id;
		logic [12:0] segment_size;
		logic [4:0]  payload_offset;
	} parse_result_t;

	typedef struct packed {
		logic [7:0]    data;
		logic          last;
		bit            typed;
		parse_result_t result;
	} stim_row_t;

	localparam parse_result_t NO_RESULT = '0;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;    // [7:0] data_byte
	logic s_tlast = 1'b0;                  // end_of_group
	logic m_tvalid;
	logic m_tready = 1'b0;
	// [3:0] group_type, [4] last_segment, [19:5] segment_number, [35:20] object_id,
	// [48:36] segment_size, [53:49] payload_offset
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;        // [3:0] status

	mot_data_group_header_parser_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	// Parser model state, one group at a time.
	logic        dir_mode;
	int          grp_index;
	logic        grp_ext;
	logic [2:0]  grp_flags;      // CRC, segment, user access
	logic [3:0]  grp_type;
	logic        grp_last_seg;
	logic [14:0] grp_segno;
	logic        grp_tid_flag;
	logic [3:0]  grp_li;
	logic [15:0] grp_tid;
	logic [12:0] grp_size;

	parse_result_t expected_results[$];
	logic [7:0]    group_bytes[$];
	stim_row_t     directed_rows[25];
	int            bytes_sent = 0;
	int            mismatches = 0;
	bit            steady = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	task automatic clear_group();
		grp_index = 0;
		grp_ext = 1'b0;
		grp_flags = '0;
		grp_type = '0;
		grp_last_seg = 1'b0;
		grp_segno = '0;
		grp_tid_flag = 1'b0;
		grp_li = '0;
		grp_tid = '0;
		grp_size = '0;
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic last, output bit done,
			output parse_result_t r);
		int pos;
		int s;
		int h;
		int len;
		logic ok_type;
		pos = grp_index;
		s = grp_ext ? 4 : 2;
		h = s + 3 + int'(grp_li);
		if (pos == 0) begin
			grp_ext = b[7];
			grp_flags = b[6:4];
			grp_type = b[3:0];
		end else if (pos == s) begin
			grp_last_seg = b[7];
			grp_segno = {b[6:0], 8'h00};
		end else if (pos == s + 1) begin
			grp_segno[7:0] = b;
		end else if (pos == s + 2) begin
			grp_tid_flag = b[4];
			grp_li = b[3:0];
		end else if (pos == s + 3) begin
			grp_tid = {b, 8'h00};
		end else if (pos == s + 4) begin
			grp_tid[7:0] = b;
		end
		// The segmentation header sits after the transport id plus any skipped bytes.
		if (pos >= s + 5 && pos == h)
			grp_size = {b[4:0], 8'h00};
		else if (pos >= s + 5 && pos == h + 1)
			grp_size[7:0] = b;
		if (grp_index < MAX_GROUP_BYTES)
			grp_index++;
		done = last;
		r = NO_RESULT;
		if (!last)
			return;
		len = grp_index;
		if (len < 2)
			r.status = ST_SHORT_GROUP_HDR;
		else if (!grp_flags[2])
			r.status = ST_NO_CRC;
		else if (!grp_flags[1])
			r.status = ST_NO_SEG_FLAG;
		else if (!grp_flags[0])
			r.status = ST_NO_USER_ACCESS;
		else if (len < s + 3)
			r.status = ST_SHORT_SESSION;
		else if (!grp_tid_flag)
			r.status = ST_NO_TID_FLAG;
		else if (grp_li < 2)
			r.status = ST_LEN_IND_LOW;
		else if (len < h)
			r.status = ST_SHORT_TID;
		else if (len < h + 2)
			r.status = ST_SHORT_SEG_HDR;
		else if (len < h + 2 + CRC_BYTES || int'(grp_size) != len - h - 2 - CRC_BYTES)
			r.status = ST_SIZE_MISMATCH;
		else begin
			ok_type = (grp_type == GT_BODY) || (grp_type == (dir_mode ? GT_DIRECTORY : GT_HEADER));
			r.status = ok_type ? ST_OK : ST_TYPE_REFUSED;
		end
		r.group_type = grp_type;
		if (r.status == ST_OK || r.status == ST_TYPE_REFUSED) begin
			r.last_segment = grp_last_seg;
			r.segment_number = grp_segno;
			r.object_id = grp_tid;
			r.segment_size = grp_size;
			r.payload_offset = 5'(h + 2);
		end
		clear_group();
	endtask

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic feed_byte(input logic [7:0] b, input logic last, input bit typed,
			input parse_result_t typed_result);
		bit done;
		parse_result_t predicted;
		predict_byte(b, last, done, predicted);
		if (done)
			expected_results.push_back(typed ? typed_result : predicted);
		while (!steady && $urandom_range(99) < 33) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_group();
		foreach (group_bytes[i])
			feed_byte(group_bytes[i], i == group_bytes.size() - 1, 1'b0, NO_RESULT);
	endtask

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255));
	endfunction

	// Builds a well-formed group around the given payload length; unless clean is set, some
	// groups get a bad flag or length indicator, a cleared tid flag, a wrong size, a cut or noise.
	task automatic build_group(input int payload_len, input bit clean);
		logic       ext;
		logic [3:0] gtype;
		logic [7:0] b0;
		int         li;
		int         announced;
		int         cut;
		group_bytes.delete();
		ext = 1'($urandom_range(1));
		case ($urandom_range(3))
			0: gtype = GT_HEADER;
			1: gtype = GT_BODY;
			2: gtype = GT_DIRECTORY;
			default: gtype = 4'($urandom_range(15));
		endcase
		b0 = {ext, 3'b111, gtype};
		if (!clean && $urandom_range(9) == 0)
			b0[6:4] = 3'($urandom_range(7));
		group_bytes.push_back(b0);
		repeat (ext ? 3 : 1) group_bytes.push_back(rand_byte());
		group_bytes.push_back(rand_byte());
		group_bytes.push_back(rand_byte());
		li = ($urandom_range(3) == 0) ? $urandom_range(15, 3) : 2;
		if (!clean && $urandom_range(9) == 0)
			li = $urandom_range(1);
		b0 = {3'($urandom_range(7)), 1'b1, 4'(li)};
		if (!clean && $urandom_range(15) == 0)
			b0[4] = 1'b0;
		group_bytes.push_back(b0);
		group_bytes.push_back(rand_byte());
		group_bytes.push_back(rand_byte());
		repeat (li - 2) group_bytes.push_back(rand_byte());
		announced = payload_len;
		if (!clean && $urandom_range(7) == 0)
			announced = $urandom_range(payload_len + 1, (payload_len > 0) ? payload_len - 1 : 0);
		group_bytes.push_back({3'($urandom_range(7)), 5'(announced >> 8)});
		group_bytes.push_back(8'(announced));
		repeat (payload_len + CRC_BYTES) group_bytes.push_back(rand_byte());
		if (!clean && $urandom_range(7) == 0) begin
			cut = $urandom_range(group_bytes.size() - 1, 1);
			while (group_bytes.size() > cut)
				void'(group_bytes.pop_back());
		end
		if (!clean && $urandom_range(15) == 0) begin
			group_bytes.delete();
			repeat ($urandom_range(12, 1)) group_bytes.push_back(rand_byte());
		end
	endtask

	task automatic set_mode(input logic mode);
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= mode;
		dir_mode = mode;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic report(input string what, input parse_result_t got, input parse_result_t want);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: status %0d/%0d type %h/%h last %b/%b segno %h/%h tid %h/%h size %h/%h offset %0d/%0d",
				what, got.status, want.status, got.group_type, want.group_type,
				got.last_segment, want.last_segment, got.segment_number, want.segment_number,
				got.object_id, want.object_id, got.segment_size, want.segment_size,
				got.payload_offset, want.payload_offset);
	endtask

	task automatic check_result();
		parse_result_t got;
		parse_result_t want;
		got.status = status_t'(m_tuser);
		got.group_type = m_tdata[3:0];
		got.last_segment = m_tdata[4];
		got.segment_number = m_tdata[19:5];
		got.object_id = m_tdata[35:20];
		got.segment_size = m_tdata[48:36];
		got.payload_offset = m_tdata[53:49];
		if (expected_results.size() == 0) begin
			report("result with no group pending (got/none)", got, NO_RESULT);
			return;
		end
		want = expected_results.pop_front();
		if (got.status != want.status || got.group_type != want.group_type ||
				got.last_segment != want.last_segment || got.segment_number != want.segment_number ||
				got.object_id != want.object_id || got.segment_size != want.segment_size ||
				got.payload_offset != want.payload_offset)
			report("result mismatch (got/expected)", got, want);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result();
	end

	always @(negedge clk) begin
		m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 33);
	end

	initial begin
		int phase_end;
		dir_mode = 1'b0;
		clear_group();
		directed_rows = '{
			// single-byte group, all bits set
			'{8'hFF, 1'b1, 1'b1, parse_result_t'{ST_SHORT_GROUP_HDR, 4'hF, 1'b0, 15'd0, 16'd0, 13'd0, 5'd0}},
			'{8'h00, 1'b0, 1'b0, NO_RESULT},
			'{8'h00, 1'b1, 1'b1, parse_result_t'{ST_NO_CRC, 4'h0, 1'b0, 15'd0, 16'd0, 13'd0, 5'd0}},
			'{8'h4F, 1'b0, 1'b0, NO_RESULT},
			'{8'h00, 1'b1, 1'b1, parse_result_t'{ST_NO_SEG_FLAG, 4'hF, 1'b0, 15'd0, 16'd0, 13'd0, 5'd0}},
			'{8'h63, 1'b0, 1'b0, NO_RESULT},
			'{8'h00, 1'b1, 1'b1, parse_result_t'{ST_NO_USER_ACCESS, 4'h3, 1'b0, 15'd0, 16'd0, 13'd0, 5'd0}},
			'{8'h73, 1'b0, 1'b0, NO_RESULT},
			'{8'h00, 1'b1, 1'b1, parse_result_t'{ST_SHORT_SESSION, 4'h3, 1'b0, 15'd0, 16'd0, 13'd0, 5'd0}},
			'{8'h73, 1'b0, 1'b0, NO_RESULT},
			'{8'h00, 1'b0, 1'b0, NO_RESULT},
			'{8'h00, 1'b0, 1'b0, NO_RESULT},
			'{8'h00, 1'b0, 1'b0, NO_RESULT},
			'{8'h00, 1'b1, 1'b1, parse_result_t'{ST_NO_TID_FLAG, 4'h3, 1'b0, 15'd0, 16'd0, 13'd0, 5'd0}},
			// shortest good body group: all-ones header fields, zero payload
			'{8'h74, 1'b0, 1'b0, NO_RESULT},
			'{8'h00, 1'b0, 1'b0, NO_RESULT},
			'{8'hFF, 1'b0, 1'b0, NO_RESULT},
			'{8'hFF, 1'b0, 1'b0, NO_RESULT},
			'{8'h12, 1'b0, 1'b0, NO_RESULT},
			'{8'hFF, 1'b0, 1'b0, NO_RESULT},
			'{8'hFF, 1'b0, 1'b0, NO_RESULT},
			'{8'h00, 1'b0, 1'b0, NO_RESULT},
			'{8'h00, 1'b0, 1'b0, NO_RESULT},
			'{8'hAB, 1'b0, 1'b0, NO_RESULT},
			'{8'hCD, 1'b1, 1'b1, parse_result_t'{ST_OK, 4'h4, 1'b1, 15'h7FFF, 16'hFFFF, 13'd0, 5'd9}}
		};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			feed_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
				directed_rows[i].result);

		// Four phases alternating the directory mode; the second runs with no idling.
		for (int ph = 0; ph < 4; ph++) begin
			s_tvalid <= 1'b0;
			set_mode(ph % 2 == 0);
			steady = (ph == 1);
			phase_end = bytes_sent + 430;
			while (bytes_sent < phase_end) begin
				build_group(($urandom_range(3) == 0) ? $urandom_range(60) : $urandom_range(12), 1'b0);
				send_group();
			end
		end
		s_tvalid <= 1'b0;
		steady = 1'b0;

		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		mismatches += expected_results.size();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: files.f
src/mdghp_pkg.sv
src/mdghp_front.sv
src/mdghp_queue.sv
src/mdghp_back.sv
src/mot_data_group_header_parser_unit.sv
bench/mot_data_group_header_parser_unit_test.sv
